/* rtl/core/uartcfr_pkg.sv */
// ----------------------------------------------------------------------------
// UART command frame receiver package
// Shared types, register codes and frame constants.
// ----------------------------------------------------------------------------
package uartcfr_pkg;

  localparam logic [4:0] FRAME_LEN  = 5'd9;
  localparam logic [4:0] COUNT_MAX  = 5'd31;
  localparam logic [1:0] IDLE_CLOSE = 2'd3;
  localparam logic [6:0] REPLY_CAP  = 7'd100;
  localparam logic [6:0] REPLY_AT   = 7'd5;
  localparam logic [6:0] REPLY_PARK = 7'd10;

  localparam logic [3:0] POS_HDR1   = 4'd0;
  localparam logic [3:0] POS_HDR2   = 4'd1;
  localparam logic [3:0] POS_ADDR   = 4'd2;
  localparam logic [3:0] POS_CMD    = 4'd3;
  localparam logic [3:0] POS_ARG0   = 4'd4;
  localparam logic [3:0] POS_ARG1   = 4'd5;
  localparam logic [3:0] POS_TGT_HI = 4'd6;
  localparam logic [3:0] POS_TGT_LO = 4'd7;
  localparam logic [3:0] POS_SUM    = 4'd8;
  localparam logic [3:0] POS_END    = 4'd9;

  localparam logic [7:0]  HEADER_FIRST_RESET     = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RESET    = 8'hAA;
  localparam logic [7:0]  DEVICE_ADDRESS_RESET   = 8'h01;
  localparam logic [7:0]  SET_COMMAND_CODE_RESET = 8'h00;
  localparam logic [15:0] INITIAL_TARGET_RESET   = 16'h0000;

  typedef enum logic [2:0] {
    CFG_HEADER_FIRST     = 3'd0,
    CFG_HEADER_SECOND    = 3'd1,
    CFG_DEVICE_ADDRESS   = 3'd2,
    CFG_SET_COMMAND_CODE = 3'd3,
    CFG_INITIAL_TARGET   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic reject;
    logic judge;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic closed;
    logic len_ok;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/uart_command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// UART command frame receiver
// Idle-timeout framing, header/address/checksum check and command dispatch.
// Each item is latched in IDLE, applied in EXEC and sorted in DECIDE; a tick
// that closes a full-length frame then scans the frame buffer read port, one
// entry per cycle, and is judged in JUDGE. Every item ends in FINISH, which
// commits the registered result once the output is free. One item at a time:
// a new item is taken only after the last one is committed. Synchronous reset
// clears control state and counters and restores register defaults.
// ----------------------------------------------------------------------------
module uart_command_frame_receiver #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        control_mode,
  input  logic        fault_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_accepted,
  output logic        frame_rejected,
  output logic        dispatch,
  output logic [7:0]  command,
  output logic [15:0] target_height,
  output logic        status_reply_due,
  output logic [15:0] good_frames,
  output logic [15:0] bad_frames
);

  uartcfr_pkg::dp_cmd_t cmd;
  uartcfr_pkg::dp_sts_t sts;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  uartcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uartcfr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .kind             (kind),
    .rx_byte          (rx_byte),
    .control_mode     (control_mode),
    .fault_active     (fault_active),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .frame_accepted   (frame_accepted),
    .frame_rejected   (frame_rejected),
    .dispatch         (dispatch),
    .command          (command),
    .target_height    (target_height),
    .status_reply_due (status_reply_due),
    .good_frames      (good_frames),
    .bad_frames       (bad_frames)
  );

endmodule

/* rtl/core/uartcfr_ctrl.sv */
// ----------------------------------------------------------------------------
// UART command frame receiver controller
// Sequences item intake, frame close, buffer scan, verdict and result commit.
// ----------------------------------------------------------------------------
module uartcfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  uartcfr_pkg::dp_sts_t sts,
  output uartcfr_pkg::dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_JUDGE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (sts.is_tick && sts.closed && sts.len_ok) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else if (sts.is_tick && sts.closed) begin
          cmd.reject = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/uartcfr_dp.sv */
// ----------------------------------------------------------------------------
// UART command frame receiver datapath
// Frame buffer, framing counters, checksum scan, command state and result.
// ----------------------------------------------------------------------------
module uartcfr_dp #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  uartcfr_pkg::dp_cmd_t cmd,
  output uartcfr_pkg::dp_sts_t sts,
  input  logic                 kind,
  input  logic [7:0]           rx_byte,
  input  logic                 control_mode,
  input  logic                 fault_active,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 frame_accepted,
  output logic                 frame_rejected,
  output logic                 dispatch,
  output logic [7:0]           command,
  output logic [15:0]          target_height,
  output logic                 status_reply_due,
  output logic [15:0]          good_frames,
  output logic [15:0]          bad_frames
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  logic        kind_q;
  logic [7:0]  rx_q;
  logic        control_q;
  logic        fault_q;

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  device_address;
  logic [7:0]  set_command_code;

  logic [4:0]  byte_count;
  logic        receiving;
  logic [1:0]  idle_ticks;
  logic [6:0]  reply_ticks;
  logic [7:0]  current_command;
  logic [15:0] current_target;
  logic [7:0]  seen_command;
  logic [15:0] seen_target;
  logic [15:0] accepted_total;
  logic [15:0] rejected_total;

  logic        closed;
  logic        len_ok;
  logic [3:0]  scan_idx;
  logic [3:0]  data_idx;
  logic        data_vld;
  logic [7:0]  rd_data;
  logic        frame_ok;
  logic [7:0]  sum;
  logic [7:0]  cap_command;
  logic [7:0]  cap_tgt_hi;
  logic [7:0]  cap_tgt_lo;
  logic        flag_acc;
  logic        flag_rej;
  logic        flag_disp;

  logic [4:0]    cnt_eff;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [1:0]    idle_inc;
  logic          close_now;
  logic [6:0]    reply_inc;
  logic [15:0]   cap_target;
  logic          pair_new;
  logic          reply_hit;

  assign cnt_eff   = receiving ? byte_count : 5'd0;
  assign wr_en     = cmd.exec && !kind_q && (cnt_eff < uartcfr_pkg::COUNT_MAX) &&
                     (32'(cnt_eff) < BUFFER_DEPTH);
  assign wr_addr   = AW'(cnt_eff);
  assign rd_en     = cmd.scan_run && (scan_idx < uartcfr_pkg::POS_END);
  assign rd_addr   = AW'(scan_idx);
  assign idle_inc  = (idle_ticks < uartcfr_pkg::IDLE_CLOSE) ? idle_ticks + 2'd1 : idle_ticks;
  assign close_now = receiving && (byte_count != 5'd0) && (idle_inc >= uartcfr_pkg::IDLE_CLOSE);
  assign reply_inc = (reply_ticks < uartcfr_pkg::REPLY_CAP) ? reply_ticks + 7'd1 : reply_ticks;
  assign cap_target = {cap_tgt_hi, cap_tgt_lo};
  assign pair_new  = !((cap_command == seen_command) && (cap_target == seen_target));
  assign reply_hit = kind_q && (reply_ticks == uartcfr_pkg::REPLY_AT);

  assign sts.is_tick   = kind_q;
  assign sts.closed    = closed;
  assign sts.len_ok    = len_ok;
  assign sts.scan_last = data_vld && (data_idx == uartcfr_pkg::POS_SUM);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q    <= kind;
      rx_q      <= rx_byte;
      control_q <= control_mode;
      fault_q   <= fault_active;
    end
    if (data_vld) begin
      unique case (data_idx)
        uartcfr_pkg::POS_CMD:    cap_command <= rd_data;
        uartcfr_pkg::POS_TGT_HI: cap_tgt_hi  <= rd_data;
        uartcfr_pkg::POS_TGT_LO: cap_tgt_lo  <= rd_data;
        default: ;
      endcase
    end
    if (cmd.commit) begin
      frame_accepted   <= flag_acc;
      frame_rejected   <= flag_rej;
      dispatch         <= flag_disp;
      command          <= current_command;
      target_height    <= current_target;
      status_reply_due <= reply_hit && (current_command != set_command_code);
      good_frames      <= accepted_total;
      bad_frames       <= rejected_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first     <= uartcfr_pkg::HEADER_FIRST_RESET;
      header_second    <= uartcfr_pkg::HEADER_SECOND_RESET;
      device_address   <= uartcfr_pkg::DEVICE_ADDRESS_RESET;
      set_command_code <= uartcfr_pkg::SET_COMMAND_CODE_RESET;
    end else if (cfg_write) begin
      unique case (uartcfr_pkg::cfg_index_t'(cfg_index))
        uartcfr_pkg::CFG_HEADER_FIRST:     header_first     <= cfg_data[7:0];
        uartcfr_pkg::CFG_HEADER_SECOND:    header_second    <= cfg_data[7:0];
        uartcfr_pkg::CFG_DEVICE_ADDRESS:   device_address   <= cfg_data[7:0];
        uartcfr_pkg::CFG_SET_COMMAND_CODE: set_command_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      receiving       <= 1'b0;
      idle_ticks      <= '0;
      reply_ticks     <= '0;
      current_command <= '0;
      current_target  <= '0;
      seen_command    <= '0;
      seen_target     <= uartcfr_pkg::INITIAL_TARGET_RESET;
      accepted_total  <= '0;
      rejected_total  <= '0;
      closed          <= 1'b0;
      len_ok          <= 1'b0;
      scan_idx        <= '0;
      data_idx        <= '0;
      data_vld        <= 1'b0;
      frame_ok        <= 1'b0;
      sum             <= '0;
      flag_acc        <= 1'b0;
      flag_rej        <= 1'b0;
      flag_disp       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.latch) begin
        flag_acc  <= 1'b0;
        flag_rej  <= 1'b0;
        flag_disp <= 1'b0;
        closed    <= 1'b0;
      end

      if (cmd.exec) begin
        if (!kind_q) begin
          receiving  <= 1'b1;
          byte_count <= (cnt_eff < uartcfr_pkg::COUNT_MAX) ? cnt_eff + 5'd1 : cnt_eff;
          idle_ticks <= '0;
        end else begin
          reply_ticks <= reply_inc;
          closed      <= close_now;
          len_ok      <= (byte_count == uartcfr_pkg::FRAME_LEN);
          if (close_now) begin
            receiving  <= 1'b0;
            byte_count <= '0;
            idle_ticks <= '0;
          end else if (receiving && (byte_count != 5'd0)) begin
            idle_ticks <= idle_inc;
          end else begin
            idle_ticks <= '0;
          end
        end
      end

      if (cmd.scan_start) begin
        scan_idx <= '0;
        data_vld <= 1'b0;
        frame_ok <= 1'b1;
        sum      <= '0;
      end

      if (cmd.scan_run) begin
        data_idx <= scan_idx;
        data_vld <= rd_en;
        if (rd_en) begin
          scan_idx <= scan_idx + 4'd1;
        end
      end

      if (data_vld) begin
        unique case (data_idx)
          uartcfr_pkg::POS_HDR1: begin
            frame_ok <= frame_ok && (rd_data == header_first);
          end
          uartcfr_pkg::POS_HDR2: begin
            frame_ok <= frame_ok && (rd_data == header_second);
          end
          uartcfr_pkg::POS_ADDR: begin
            frame_ok <= frame_ok && (rd_data == device_address);
            sum      <= rd_data;
          end
          uartcfr_pkg::POS_SUM: begin
            frame_ok <= frame_ok && (rd_data == sum);
          end
          default: begin
            sum <= sum + rd_data;
          end
        endcase
      end

      if (cmd.reject) begin
        rejected_total <= rejected_total + 16'd1;
        flag_rej       <= 1'b1;
      end

      if (cmd.judge) begin
        if (frame_ok) begin
          current_command <= cap_command;
          current_target  <= cap_target;
          accepted_total  <= accepted_total + 16'd1;
          reply_ticks     <= '0;
          flag_acc        <= 1'b1;
          if (control_q && pair_new) begin
            seen_command <= cap_command;
            seen_target  <= cap_target;
            flag_disp    <= !fault_q;
          end
        end else begin
          rejected_total <= rejected_total + 16'd1;
          flag_rej       <= 1'b1;
        end
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (reply_hit) begin
          reply_ticks <= uartcfr_pkg::REPLY_PARK;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
